// ===== sv/luhn_pkg.sv =====
// ----------------------------------------------------------------------------
// luhn_pkg
// Shared types and constants for the card number Luhn classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package luhn_pkg;

    localparam int BIN_W      = 54;
    localparam int NUM_DIGITS = 17;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int IN_W       = 56;
    localparam int OUT_W      = 8;
    localparam int STEP_W     = 6;
    localparam int COUNT_W    = 5;

    localparam logic [1:0] VERDICT_INVALID = 2'd0;
    localparam logic [1:0] VERDICT_BRAND1  = 2'd1;
    localparam logic [1:0] VERDICT_BRAND2  = 2'd2;
    localparam logic [1:0] VERDICT_BRAND3  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic convert;
        logic scan;
        logic emit;
    } luhn_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic scan_last;
        logic out_free;
    } luhn_sts_t;

endpackage

`default_nettype wire

// ===== sv/luhn_ctrl.sv =====
// ----------------------------------------------------------------------------
// luhn_ctrl
// Sequencer: load, binary to BCD conversion, digit scan, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module luhn_ctrl
    import luhn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire luhn_sts_t sts,
    output luhn_cmd_t      cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (sts.conv_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CONVERT:
            begin
                cmd.convert = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONVERT && sts.conv_last) |=> (state_reg == ST_SCAN))
        else $error("conversion end did not start scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_CONVERT))
        else $error("load did not start conversion");

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load, cmd.convert, cmd.scan, cmd.emit}) <= 1)
        else $error("more than one datapath command");

endmodule

`default_nettype wire

// ===== sv/luhn_datapath.sv =====
// ----------------------------------------------------------------------------
// luhn_datapath
// Shift-add-3 BCD converter, serial Luhn digit accumulator, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module luhn_datapath
    import luhn_pkg::*;
#(
    parameter int MAX_DIGITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [BIN_W-1:0] card_number,
    input  wire luhn_cmd_t        cmd,
    output luhn_sts_t             sts,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [1:0]            out_verdict,
    output logic                  out_checksum_ok,
    output logic [COUNT_W-1:0]    out_digit_count
);

    logic [BIN_W-1:0]   bin_reg,   bin_next;
    logic [BCD_W-1:0]   bcd_reg,   bcd_next;
    logic [STEP_W-1:0]  step_reg,  step_next;
    logic [3:0]         total_reg, total_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [3:0]         lead1_reg, lead1_next;
    logic [6:0]         lead2_reg, lead2_next;
    logic [3:0]         prev_reg,  prev_next;
    logic               out_valid_reg;
    logic [1:0]         verdict_reg;
    logic               ok_reg;
    logic [COUNT_W-1:0] dcount_reg;

    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         digit;
    logic [3:0]         contrib;
    logic [4:0]         sum;
    logic [4:0]         dbl;
    logic               checksum_ok;
    logic [1:0]         verdict;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    assign digit   = bcd_reg[3:0];
    assign dbl     = {digit, 1'b0};
    assign contrib = step_reg[0] ? ((dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0]) : digit;
    assign sum     = {1'b0, total_reg} + {1'b0, contrib};

    assign sts.conv_last = cmd.convert && (step_reg == STEP_W'(BIN_W - 1));
    assign sts.scan_last = cmd.scan && (step_reg == STEP_W'(NUM_DIGITS - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        total_next = total_reg;
        count_next = count_reg;
        lead1_next = lead1_reg;
        lead2_next = lead2_reg;
        prev_next  = prev_reg;
        if (cmd.load)
        begin
            bin_next   = card_number;
            bcd_next   = '0;
            step_next  = '0;
            total_next = '0;
            count_next = '0;
            lead1_next = '0;
            lead2_next = '0;
            prev_next  = '0;
        end
        else if (cmd.convert)
        begin
            bcd_next  = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_next  = {bin_reg[BIN_W-2:0], 1'b0};
            step_next = sts.conv_last ? '0 : step_reg + 1'b1;
        end
        else if (cmd.scan)
        begin
            bcd_next   = {4'd0, bcd_reg[BCD_W-1:4]};
            step_next  = step_reg + 1'b1;
            total_next = (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
            prev_next  = digit;
            if (digit != 4'd0)
            begin
                count_next = step_reg[COUNT_W-1:0] + 1'b1;
                lead1_next = digit;
                lead2_next = 7'({3'd0, digit} * 7'd10) + {3'd0, prev_reg};
            end
        end
    end

    always_comb
    begin
        verdict = VERDICT_INVALID;
        if (checksum_ok && (count_reg >= 5'd1) && (count_reg <= COUNT_W'(MAX_DIGITS)))
        begin
            if ((count_reg == 5'd15) && ((lead2_reg == 7'd34) || (lead2_reg == 7'd37)))
            begin
                verdict = VERDICT_BRAND1;
            end
            else if ((count_reg == 5'd16) && (lead2_reg >= 7'd51) && (lead2_reg <= 7'd55))
            begin
                verdict = VERDICT_BRAND2;
            end
            else if ((lead1_reg == 4'd4) && ((count_reg == 5'd13) || (count_reg == 5'd16)))
            begin
                verdict = VERDICT_BRAND3;
            end
        end
    end

    assign checksum_ok = (total_reg == 4'd0);

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        step_reg  <= step_next;
        total_reg <= total_next;
        count_reg <= count_next;
        lead1_reg <= lead1_next;
        lead2_reg <= lead2_next;
        prev_reg  <= prev_next;
        if (cmd.emit)
        begin
            verdict_reg <= verdict;
            ok_reg      <= checksum_ok;
            dcount_reg  <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_verdict     = verdict_reg;
    assign out_checksum_ok = ok_reg;
    assign out_digit_count = dcount_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (digit <= 4'd9))
        else $error("BCD digit out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (count_reg <= COUNT_W'(NUM_DIGITS)))
        else $error("digit count beyond converter width");

endmodule

`default_nettype wire

// ===== sv/card_number_luhn_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_unit
// Luhn mod-10 check and brand classification of a binary card number.
// ----------------------------------------------------------------------------
// channel   direction  tdata fields (low bit up)
// s_axis    in         card_number[53:0], pad[55:54]
// m_axis    out        verdict[1:0], checksum_ok[2], digit_count[7:3]
//
// An item goes from acceptance to result through a load step, 54
// shift-add-3 conversion steps (one per input bit), 17 digit scan steps
// (one per BCD digit) and a hand-off step.
// A new item is accepted while a finished result still waits in the output
// register; the hand-off stalls only if that register is still full.
// rst_n clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module card_number_luhn_classifier_unit
    import luhn_pkg::*;
#(
    parameter int MAX_DIGITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,   // card_number[53:0], pad
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata    // verdict, checksum_ok, digit_count
);

    luhn_cmd_t          cmd;
    luhn_sts_t          sts;
    logic [1:0]         verdict;
    logic               checksum_ok;
    logic [COUNT_W-1:0] digit_count;

    luhn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    luhn_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .card_number     (s_axis_tdata[BIN_W-1:0]),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_verdict     (verdict),
        .out_checksum_ok (checksum_ok),
        .out_digit_count (digit_count)
    );

    assign m_axis_tdata = {digit_count, checksum_ok, verdict};

endmodule

`default_nettype wire

// ===== tb/luhn_result_checker.sv =====
// ----------------------------------------------------------------------------
// luhn_result_checker
// Watches both stream channels of the card classifier. It predicts verdict,
// mod-10 flag and digit count for every accepted card number and compares
// each returned item, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module luhn_result_checker
    import luhn_pkg::*;
#(
    parameter int MAX_DIGITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    input  wire logic             s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,   // card_number[53:0], pad
    input  wire logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire logic [OUT_W-1:0] m_axis_tdata,   // verdict, checksum_ok, digit_count
    output int unsigned           failures,
    output int unsigned           outstanding,
    output int unsigned           results_seen,
    output int unsigned           luhn_passes,
    output int unsigned           brand_matches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COUNT_W-1:0] digit_count;
        logic               checksum_ok;
        logic [1:0]         verdict;
    } card_result_t;

    card_result_t expected_q[$];

    function automatic card_result_t classify_card(input logic [BIN_W-1:0] card);
        card_result_t res;
        logic [BIN_W-1:0] rest;
        int unsigned digit;
        int unsigned doubled;
        int unsigned total;
        int unsigned count;
        int unsigned lead1;
        int unsigned lead2;
        int unsigned prev;
        rest  = card;
        total = 0;
        count = 0;
        lead1 = 0;
        lead2 = 0;
        prev  = 0;
        while (rest != '0)
        begin
            digit = int'(rest % 10);
            rest  = rest / 10;
            if (count % 2 == 1)
            begin
                doubled = 2 * digit;
                total += (doubled > 9) ? doubled - 9 : doubled;
            end
            else
            begin
                total += digit;
            end
            count++;
            lead2 = digit * 10 + prev;
            lead1 = digit;
            prev  = digit;
        end
        res.checksum_ok = (total % 10 == 0);
        res.digit_count = COUNT_W'(count);
        res.verdict     = VERDICT_INVALID;
        if (res.checksum_ok && count >= 1 && count <= MAX_DIGITS)
        begin
            if (count == 15 && (lead2 == 34 || lead2 == 37))
                res.verdict = VERDICT_BRAND1;
            else if (count == 16 && lead2 >= 51 && lead2 <= 55)
                res.verdict = VERDICT_BRAND2;
            else if (lead1 == 4 && (count == 13 || count == 16))
                res.verdict = VERDICT_BRAND3;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        card_result_t got;
        card_result_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            failures      = 0;
            results_seen  = 0;
            luhn_passes   = 0;
            brand_matches = 0;
            outstanding  <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(classify_card(s_axis_tdata[BIN_W-1:0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = card_result_t'(m_axis_tdata);
                if (expected_q.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected item, expected none, actual %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = expected_q.pop_front();
                    results_seen++;
                    if (want.checksum_ok)
                        luhn_passes++;
                    if (want.verdict != VERDICT_INVALID)
                        brand_matches++;
                    if (got.verdict !== want.verdict)
                    begin
                        failures++;
                        $display("%0t: verdict mismatch, expected %0d, actual %0d",
                                 $time, want.verdict, got.verdict);
                    end
                    if (got.checksum_ok !== want.checksum_ok)
                    begin
                        failures++;
                        $display("%0t: checksum_ok mismatch, expected %0d, actual %0d",
                                 $time, want.checksum_ok, got.checksum_ok);
                    end
                    if (got.digit_count !== want.digit_count)
                    begin
                        failures++;
                        $display("%0t: digit_count mismatch, expected %0d, actual %0d",
                                 $time, want.digit_count, got.digit_count);
                    end
                end
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives card numbers into the Luhn classifier: a directed set of corner
// cases, then random well-formed card layouts, near misses and raw values,
// with random gaps and stalls on both channels and two long output stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import luhn_pkg::*;

    localparam int          MAX_DIGITS   = 16;
    localparam int          RANDOM_ITEMS = 1325;
    localparam int          LONG_HOLD    = 600;
    localparam int          DRAIN_CYCLES = 100;
    localparam int unsigned CYCLE_LIMIT  = 800000;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    int unsigned failures;
    int unsigned outstanding;
    int unsigned results_seen;
    int unsigned luhn_passes;
    int unsigned brand_matches;
    int unsigned cycle_count;
    int unsigned cards_sent;
    int unsigned results_taken;
    bit          hold_request;

    card_number_luhn_classifier_unit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    luhn_result_checker #(
        .MAX_DIGITS (MAX_DIGITS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .failures      (failures),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .luhn_passes   (luhn_passes),
        .brand_matches (brand_matches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Build a number of len digits with the given leading digits and a
    // final digit that makes the mod-10 total pass, or deliberately fail.
    function automatic logic [BIN_W-1:0] make_card(input int unsigned lead,
                                                   input int unsigned lead_digits,
                                                   input int unsigned len,
                                                   input bit          luhn_valid);
        logic [63:0] number;
        int unsigned sum;
        int unsigned digit;
        int unsigned pos;
        int unsigned check;
        number = '0;
        sum    = 0;
        for (int i = 0; i < len; i++)
        begin
            pos = len - i;
            if (pos == 1)
                digit = 0;
            else if (i < lead_digits)
                digit = (i == 0 && lead_digits == 2) ? lead / 10 : lead % 10;
            else
                digit = $urandom_range(9);
            if (pos % 2 == 0)
                sum += (2 * digit > 9) ? 2 * digit - 9 : 2 * digit;
            else
                sum += digit;
            number = number * 10 + digit;
        end
        check = (10 - sum % 10) % 10;
        if (!luhn_valid)
            check = (check + $urandom_range(1, 9)) % 10;
        return BIN_W'(number + check);
    endfunction

    task automatic send_card(input logic [BIN_W-1:0] card);
        int unsigned gap;
        gap = (((cards_sent / 100) % 3) == 1) ? 0 : $urandom_range(12);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - BIN_W){1'b0}}, card};
        do
            @(posedge clk);
        while (!s_axis_tready);
        cards_sent++;
    endtask

    initial
    begin : receiver
        int unsigned stall;
        results_taken = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = (((results_taken / 80) % 3) == 2) ? 0 : $urandom_range(12);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            results_taken++;
        end
    end

    initial
    begin : stimulus
        int unsigned       kind;
        int unsigned       len;
        int unsigned       lead;
        logic [63:0]       wide;
        logic [BIN_W-1:0]  card;
        cards_sent    = 0;
        hold_request  = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_card('0);
        send_card(BIN_W'(1));
        send_card(BIN_W'(59));
        send_card({BIN_W{1'b1}});
        send_card(BIN_W'(64'd9999999999999999));
        send_card(BIN_W'(64'd10000000000000000));
        send_card(BIN_W'(64'd10000000000000));
        send_card(BIN_W'(64'd100000000000000));
        send_card(make_card(34, 2, 15, 1'b1));
        send_card(make_card(37, 2, 15, 1'b1));
        send_card(make_card(37, 2, 15, 1'b0));
        send_card(make_card(51, 2, 16, 1'b1));
        send_card(make_card(55, 2, 16, 1'b1));
        send_card(make_card(53, 2, 16, 1'b0));
        send_card(make_card(4, 1, 13, 1'b1));
        send_card(make_card(4, 1, 16, 1'b1));
        send_card(make_card(4, 1, 16, 1'b0));
        send_card(make_card(35, 2, 15, 1'b1));
        send_card(make_card(56, 2, 16, 1'b1));
        send_card(make_card(50, 2, 16, 1'b1));
        send_card(make_card(4, 1, 15, 1'b1));
        send_card(make_card(34, 2, 16, 1'b1));
        send_card(make_card(4, 1, 14, 1'b1));
        send_card(make_card(12, 2, 17, 1'b1));
        send_card(make_card(4, 1, 12, 1'b1));
        hold_request = 1'b1;

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                hold_request = 1'b1;
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                case ($urandom_range(2))
                    0:       card = make_card($urandom_range(1) ? 37 : 34, 2, 15,
                                              $urandom_range(9) != 0);
                    1:       card = make_card($urandom_range(51, 55), 2, 16,
                                              $urandom_range(9) != 0);
                    default: card = make_card(4, 1, $urandom_range(1) ? 16 : 13,
                                              $urandom_range(9) != 0);
                endcase
            end
            else if (kind < 60)
            begin
                card = make_card($urandom_range(30, 59), 2, $urandom_range(12, 16),
                                 $urandom_range(1));
            end
            else if (kind < 78)
            begin
                len  = $urandom_range(1, 17);
                lead = (len == 17) ? $urandom_range(10, 17) : $urandom_range(10, 99);
                card = make_card(lead, (len > 2) ? 2 : 1, len, $urandom_range(1));
            end
            else
            begin
                wide = {$urandom(), $urandom()};
                card = wide[BIN_W-1:0] >> $urandom_range(BIN_W - 1);
            end
            send_card(card);
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d card numbers, checked %0d results: %0d passed mod-10, %0d matched a brand.",
                 cards_sent, results_seen, luhn_passes, brand_matches);
        $display("Covered zero, 17-digit values, brand layouts, near misses and two long output stalls.");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
